@@ sv/rors_pkg.sv @@
// shared constants and control types for the reading-order rectangle sorter
`default_nettype none

package rors_pkg;

   // fixed width of every coordinate field on the channels
   localparam int FIELD_BITS = 12;

   // defaults for the top-level parameters
   localparam int MAX_RECTS_DEF  = 64;
   localparam int COORD_BITS_DEF = 12;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;      // input transfer: store rectangle or flag a drop
      logic start;     // clear outer and output indexes
      logic read_i;    // read entry i
      logic take_i;    // hold entry i, start inner pass at j = 0
      logic step_j;    // compare entry j with held entry, swap if needed
      logic write_i;   // write held entry back to slot i, advance i
      logic read_k;    // read entry k for output
      logic show;      // load output register from read data
      logic next_k;    // advance output index
      logic done;      // run finished, empty the store
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic n_small;   // fewer than two rectangles held
      logic i_last;
      logic j_last;
      logic k_last;
   } sts_type;

endpackage

`default_nettype wire

@@ sv/rors_req_if.sv @@
// input channel: one rectangle per transfer
`default_nettype none

interface rors_req_if;
   logic                            valid;
   logic                            ready;
   logic [rors_pkg::FIELD_BITS-1:0] rect_x;
   logic [rors_pkg::FIELD_BITS-1:0] rect_y;
   logic [rors_pkg::FIELD_BITS-1:0] rect_width;
   logic [rors_pkg::FIELD_BITS-1:0] rect_height;
   logic                            final_item;

   modport source (output valid, rect_x, rect_y, rect_width, rect_height, final_item,
                   input ready);
   modport sink (input valid, rect_x, rect_y, rect_width, rect_height, final_item,
                 output ready);
endinterface

`default_nettype wire

@@ sv/rors_rsp_if.sv @@
// result channel: one sorted rectangle per transfer
`default_nettype none

interface rors_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rors_pkg::FIELD_BITS-1:0] out_x;
   logic [rors_pkg::FIELD_BITS-1:0] out_y;
   logic [rors_pkg::FIELD_BITS-1:0] out_width;
   logic [rors_pkg::FIELD_BITS-1:0] out_height;
   logic                            out_final;
   logic                            overflowed;

   modport source (output valid, out_x, out_y, out_width, out_height, out_final, overflowed,
                   input ready);
   modport sink (input valid, out_x, out_y, out_width, out_height, out_final, overflowed,
                 output ready);
endinterface

`default_nettype wire

@@ sv/rors_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none

module rors_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/rors_ctrl.sv @@
// controller: load, sort and emit sequencing
`default_nettype none

module rors_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_final,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire rors_pkg::sts_type sts,
   output rors_pkg::cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_START  = 3'd1;
   localparam logic [2:0] ST_RD_I   = 3'd2;
   localparam logic [2:0] ST_TAKE_I = 3'd3;
   localparam logic [2:0] ST_INNER  = 3'd4;
   localparam logic [2:0] ST_WB     = 3'd5;
   localparam logic [2:0] ST_RD_K   = 3'd6;
   localparam logic [2:0] ST_SHOW   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       hold_ff;
   logic       hold_in;

   // hold_ff marks the output register as full; it overlays the idle code
   always_comb begin
      state_in = state_ff;
      hold_in  = hold_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (hold_ff) begin
               if (rsp_ready) begin
                  hold_in = 1'b0;
                  if (sts.k_last) begin
                     cmd.done = 1'b1;
                  end else begin
                     cmd.next_k = 1'b1;
                     state_in   = ST_RD_K;
                  end
               end
            end else if (req_valid) begin
               cmd.load = 1'b1;
               if (req_final) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            state_in  = sts.n_small ? ST_RD_K : ST_RD_I;
         end
         ST_RD_I: begin
            cmd.read_i = 1'b1;
            state_in   = ST_TAKE_I;
         end
         ST_TAKE_I: begin
            cmd.take_i = 1'b1;
            state_in   = ST_INNER;
         end
         ST_INNER: begin
            cmd.step_j = 1'b1;
            if (sts.j_last) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            cmd.write_i = 1'b1;
            state_in    = sts.i_last ? ST_RD_K : ST_RD_I;
         end
         ST_RD_K: begin
            cmd.read_k = 1'b1;
            state_in   = ST_SHOW;
         end
         ST_SHOW: begin
            cmd.show = 1'b1;
            hold_in  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hold_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         hold_ff  <= hold_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE) && !hold_ff;
   assign rsp_valid = hold_ff;

endmodule

`default_nettype wire

@@ sv/rors_dpath.sv @@
// datapath: rectangle store, indexes, compare-swap and output register
`default_nettype none

module rors_dpath #(
   parameter int MAX_RECTS  = rors_pkg::MAX_RECTS_DEF,
   parameter int COORD_BITS = rors_pkg::COORD_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire rors_pkg::cmd_type               cmd,
   output rors_pkg::sts_type                    sts,
   input  wire logic [rors_pkg::FIELD_BITS-1:0] in_x,
   input  wire logic [rors_pkg::FIELD_BITS-1:0] in_y,
   input  wire logic [rors_pkg::FIELD_BITS-1:0] in_w,
   input  wire logic [rors_pkg::FIELD_BITS-1:0] in_h,
   output logic      [rors_pkg::FIELD_BITS-1:0] out_x,
   output logic      [rors_pkg::FIELD_BITS-1:0] out_y,
   output logic      [rors_pkg::FIELD_BITS-1:0] out_w,
   output logic      [rors_pkg::FIELD_BITS-1:0] out_h,
   output logic                                 out_last,
   output logic                                 out_ovf
);

   localparam int AW = $clog2(MAX_RECTS);
   localparam int CW = $clog2(MAX_RECTS + 1);
   localparam int CB = COORD_BITS;
   localparam int EW = 4 * COORD_BITS;
   localparam int FB = rors_pkg::FIELD_BITS;

   logic [CW-1:0] count_ff;
   logic          drop_ff;
   logic [AW-1:0] i_ff;
   logic [AW-1:0] j_ff;
   logic [AW-1:0] k_ff;
   logic [EW-1:0] held_ff;
   logic [FB-1:0] x_ff;
   logic [FB-1:0] y_ff;
   logic [FB-1:0] w_ff;
   logic [FB-1:0] h_ff;
   logic          last_ff;
   logic          ovf_ff;

   logic          full;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic [EW-1:0] rd_data;
   logic [EW-1:0] in_entry;
   logic [CB-1:0] xj, yj, hj, xi, yi, ydist;
   logic          swap;

   rors_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_RECTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // entry layout: x, y, width, height from the top down
   assign in_entry = {CB'(in_x), CB'(in_y), CB'(in_w), CB'(in_h)};

   assign xj = rd_data[EW-1 -: CB];
   assign yj = rd_data[3*CB-1 -: CB];
   assign hj = rd_data[CB-1:0];
   assign xi = held_ff[EW-1 -: CB];
   assign yi = held_ff[3*CB-1 -: CB];

   // memory copy of slot i is stale while it is held, so skip j == i
   assign ydist = (yj >= yi) ? (yj - yi) : (yi - yj);
   assign swap  = (j_ff != i_ff) && ((ydist <= hj) ? (xj > xi) : (yj > yi));

   assign full = (count_ff == CW'(MAX_RECTS));

   assign sts.n_small = (count_ff < CW'(2));
   assign sts.i_last  = (CW'(i_ff) == (count_ff - CW'(1)));
   assign sts.j_last  = (CW'(j_ff) == (count_ff - CW'(2)));
   assign sts.k_last  = (CW'(k_ff) == (count_ff - CW'(1)));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = in_entry;
      if (cmd.load) begin
         wr_en = !full;
      end else if (cmd.step_j) begin
         wr_en   = swap;
         wr_addr = j_ff;
         wr_data = held_ff;
      end else if (cmd.write_i) begin
         wr_en   = 1'b1;
         wr_addr = i_ff;
         wr_data = held_ff;
      end
   end

   // step_j fetches the next j while the current one is compared
   always_comb begin
      rd_addr = k_ff;
      if (cmd.read_i) begin
         rd_addr = i_ff;
      end else if (cmd.take_i) begin
         rd_addr = '0;
      end else if (cmd.step_j) begin
         rd_addr = j_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         drop_ff  <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         if (cmd.load) begin
            if (full) begin
               drop_ff <= 1'b1;
            end else begin
               count_ff <= count_ff + CW'(1);
            end
         end
         if (cmd.start) begin
            i_ff <= '0;
            k_ff <= '0;
         end
         if (cmd.take_i) begin
            j_ff <= '0;
         end
         if (cmd.step_j) begin
            j_ff <= j_ff + AW'(1);
         end
         if (cmd.write_i) begin
            i_ff <= i_ff + AW'(1);
         end
         if (cmd.next_k) begin
            k_ff <= k_ff + AW'(1);
         end
         if (cmd.done) begin
            count_ff <= '0;
            drop_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_i || (cmd.step_j && swap)) begin
         held_ff <= rd_data;
      end
      if (cmd.show) begin
         x_ff    <= FB'(rd_data[EW-1 -: CB]);
         y_ff    <= FB'(rd_data[3*CB-1 -: CB]);
         w_ff    <= FB'(rd_data[2*CB-1 -: CB]);
         h_ff    <= FB'(rd_data[CB-1:0]);
         last_ff <= sts.k_last;
         ovf_ff  <= drop_ff;
      end
   end

   assign out_x    = x_ff;
   assign out_y    = y_ff;
   assign out_w    = w_ff;
   assign out_h    = h_ff;
   assign out_last = last_ff;
   assign out_ovf  = ovf_ff;

endmodule

`default_nettype wire

@@ sv/reading_order_rect_sort_top.sv @@
// Reading-order rectangle sorter, top level.
// The req channel takes one rectangle (x, y, width, height) per transfer, one
// transfer per cycle while loading. Up to MAX_RECTS rectangles are stored; any
// more are dropped and reported through overflowed on every result of the run.
// A transfer with final_item set closes the set: req.ready then drops and the
// block sorts the stored n rectangles (if n >= 2) in place by exchange sort,
// one compare-swap per cycle against a held entry, bound by the single read
// and single write port of the rectangle store. An outer pass reads entry i,
// holds it, steps j through the store and writes it back to slot i.
// The sorted rectangles then leave on the rsp channel, out_final marking the
// last; each result is read from the store, loaded into the output register
// and transferred before the next is read. While rsp.ready is low the result
// holds in the output register and nothing advances. After the last result the
// block takes a new set. Reset (synchronous, active high) empties the store
// and clears the drop flag; store contents are not cleared, only slots written
// in the current load are ever read.
`default_nettype none

module reading_order_rect_sort_top #(
   parameter int MAX_RECTS  = rors_pkg::MAX_RECTS_DEF,
   parameter int COORD_BITS = rors_pkg::COORD_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   rors_req_if.sink   req,
   rors_rsp_if.source rsp
);

   rors_pkg::cmd_type cmd;
   rors_pkg::sts_type sts;

   rors_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_final (req.final_item),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rors_dpath #(
      .MAX_RECTS  (MAX_RECTS),
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .in_x     (req.rect_x),
      .in_y     (req.rect_y),
      .in_w     (req.rect_width),
      .in_h     (req.rect_height),
      .out_x    (rsp.out_x),
      .out_y    (rsp.out_y),
      .out_w    (rsp.out_width),
      .out_h    (rsp.out_height),
      .out_last (rsp.out_final),
      .out_ovf  (rsp.overflowed)
   );

endmodule

`default_nettype wire

@@ sv/rors_chk.sv @@
// port-level checker for the rectangle sorter and its bind
`default_nettype none

module rors_chk (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            req_final,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic                            rsp_final,
   input wire logic [rors_pkg::FIELD_BITS-1:0] rsp_x,
   input wire logic [rors_pkg::FIELD_BITS-1:0] rsp_y,
   input wire logic                            rsp_ovf
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_x) && $stable(rsp_y)
         && $stable(rsp_ovf) && $stable(rsp_final))
      else $error("stalled result changed");

   // loading and emitting never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while a result is shown");

   // after the final rectangle is taken, input is not ready and no result is shown yet
   a_final_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_final |=> !req_ready && !rsp_valid)
      else $error("input taken right after the final rectangle");

   // the last result ends the run and reopens input
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_final |=> !rsp_valid && req_ready)
      else $error("run did not end after the last result");

endmodule

bind reading_order_rect_sort_top rors_chk u_rors_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .req_final (req.final_item),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_final (rsp.out_final),
   .rsp_x     (rsp.out_x),
   .rsp_y     (rsp.out_y),
   .rsp_ovf   (rsp.overflowed)
);

`default_nettype wire
